[sv/urb_pkg.sv]
package urb_pkg;

   localparam int RING_DEPTH = 1024;
   localparam int PTR_W      = $clog2(RING_DEPTH);
   localparam int FILL_W     = $clog2(RING_DEPTH + 1);

   localparam int OP_W   = 3;
   localparam int BYTE_W = 8;
   localparam int WORD_W = 32;

   typedef enum logic [OP_W-1:0] {
      OP_RX_IN    = 3'd0,
      OP_RX_TAKE  = 3'd1,
      OP_TX_PUT   = 3'd2,
      OP_TX_HEX   = 3'd3,
      OP_TX_READY = 3'd4
   } op_type;

   localparam logic [BYTE_W-1:0] CH_LF         = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_CR         = 8'h0D;
   localparam logic [BYTE_W-1:0] HEX_DIGIT_OFS = 8'h30;
   localparam logic [BYTE_W-1:0] HEX_ALPHA_OFS = 8'h57;
   localparam logic [3:0]        NIBBLE_TEN    = 4'd10;

   // Command from the sequencer into one ring.
   typedef struct packed {
      logic              push;
      logic              pop;
      logic [BYTE_W-1:0] wdata;
   } ring_cmd_type;

   // Status of one ring back to the sequencer.
   typedef struct packed {
      logic              full;
      logic              empty;
      logic [BYTE_W-1:0] rdata;
   } ring_stat_type;

endpackage

[sv/urb_if.sv]
interface urb_req_if import urb_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   operation;
   logic [BYTE_W-1:0] data_byte;
   logic [WORD_W-1:0] hex_word;

   modport source (output valid, operation, data_byte, hex_word, input ready);
   modport sink   (input valid, operation, data_byte, hex_word, output ready);
endinterface

interface urb_rsp_if import urb_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] out_byte;
   logic              out_valid;
   logic              line_end;
   logic              overflow;
   logic              rx_empty;
   logic              tx_empty;

   modport source (output valid, out_byte, out_valid, line_end, overflow, rx_empty,
                   tx_empty, input ready);
   modport sink   (input valid, out_byte, out_valid, line_end, overflow, rx_empty,
                   tx_empty, output ready);
endinterface

[sv/urb_ring.sv]
module urb_ring import urb_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  ring_cmd_type  cmd,
   output ring_stat_type stat
);

   logic [BYTE_W-1:0] mem [RING_DEPTH];
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [BYTE_W-1:0] rdata_ff;
   logic              do_push, do_pop;

   assign stat.full  = (fill_ff == FILL_W'(RING_DEPTH));
   assign stat.empty = (fill_ff == '0);
   assign stat.rdata = rdata_ff;

   assign do_push = cmd.push && !stat.full;
   assign do_pop  = cmd.pop && !stat.empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(RING_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(RING_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Storage with one write and one registered read port.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= cmd.wdata;
      end
      if (do_pop) begin
         rdata_ff <= mem[rd_ptr_ff];
      end
   end

endmodule

[sv/urb_ctrl.sv]
module urb_ctrl import urb_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   urb_req_if.sink       req,
   urb_rsp_if.source     rsp,
   output ring_cmd_type  rx_cmd,
   output ring_cmd_type  tx_cmd,
   input  ring_stat_type rx_stat,
   input  ring_stat_type tx_stat
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_PUSH   = 4'b0010,
      ST_POP    = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   state_type         state_ff, state_in;
   logic [OP_W-1:0]   op_ff, op_in;
   logic [BYTE_W-1:0] data_ff, data_in;
   logic [WORD_W-1:0] word_ff, word_in;
   logic [3:0]        cnt_ff, cnt_in;
   logic              to_rx_ff, to_rx_in;
   logic              ovf_ff, ovf_in;
   logic              popped_ff, popped_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] rsp_byte_ff, rsp_byte_in;
   logic              rsp_bvalid_ff, rsp_bvalid_in;
   logic              rsp_lend_ff, rsp_lend_in;
   logic              rsp_ovf_ff, rsp_ovf_in;
   logic              rsp_rxe_ff, rsp_rxe_in;
   logic              rsp_txe_ff, rsp_txe_in;

   logic              accept;
   logic              load_rsp;
   logic              target_full;
   logic [BYTE_W-1:0] push_char;
   logic [BYTE_W-1:0] pop_byte;

   // Character unit: one nibble becomes one lowercase hex character.
   function automatic logic [BYTE_W-1:0] hex_char(input logic [3:0] nib);
      logic [BYTE_W-1:0] ext;
      ext = {4'b0, nib};
      return (nib >= NIBBLE_TEN) ? ext + HEX_ALPHA_OFS : ext + HEX_DIGIT_OFS;
   endfunction

   assign req.ready = (state_ff == ST_IDLE);
   assign accept    = req.valid && req.ready;
   assign load_rsp  = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp.ready);

   assign target_full = to_rx_ff ? rx_stat.full : tx_stat.full;

   always_comb begin
      if (op_ff == OP_TX_HEX) begin
         push_char = hex_char(word_ff[WORD_W-1 -: 4]);
      end else if (data_ff == CH_LF && cnt_ff == 4'd2) begin
         push_char = CH_CR;
      end else begin
         push_char = data_ff;
      end
   end

   assign pop_byte = (op_ff == OP_RX_TAKE) ? rx_stat.rdata : tx_stat.rdata;

   always_comb begin
      rx_cmd       = '0;
      tx_cmd       = '0;
      rx_cmd.wdata = push_char;
      tx_cmd.wdata = push_char;
      if (state_ff == ST_PUSH && !target_full) begin
         rx_cmd.push = to_rx_ff;
         tx_cmd.push = !to_rx_ff;
      end
      if (state_ff == ST_POP) begin
         rx_cmd.pop = (op_ff == OP_RX_TAKE) && !rx_stat.empty;
         tx_cmd.pop = (op_ff == OP_TX_READY) && !tx_stat.empty;
      end
   end

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      data_in   = data_ff;
      word_in   = word_ff;
      cnt_in    = cnt_ff;
      to_rx_in  = to_rx_ff;
      ovf_in    = ovf_ff;
      popped_in = popped_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in     = req.operation;
               data_in   = req.data_byte;
               word_in   = req.hex_word;
               ovf_in    = 1'b0;
               popped_in = 1'b0;
               to_rx_in  = 1'b0;
               cnt_in    = 4'd0;
               unique case (req.operation) inside
                  OP_RX_IN: begin
                     to_rx_in = 1'b1;
                     cnt_in   = 4'd1;
                     state_in = ST_PUSH;
                  end
                  OP_TX_PUT: begin
                     if (req.data_byte == '0) begin
                        state_in = ST_FINISH;
                     end else begin
                        cnt_in   = (req.data_byte == CH_LF) ? 4'd2 : 4'd1;
                        state_in = ST_PUSH;
                     end
                  end
                  OP_TX_HEX: begin
                     cnt_in   = 4'd8;
                     state_in = ST_PUSH;
                  end
                  OP_RX_TAKE, OP_TX_READY: begin
                     state_in = ST_POP;
                  end
                  default: begin
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end
         ST_PUSH: begin
            if (target_full) begin
               ovf_in = 1'b1;
            end
            word_in = {word_ff[WORD_W-5:0], 4'b0};
            cnt_in  = cnt_ff - 1'b1;
            if (cnt_ff == 4'd1) begin
               state_in = ST_FINISH;
            end
         end
         ST_POP: begin
            popped_in = rx_cmd.pop || tx_cmd.pop;
            state_in  = ST_FINISH;
         end
         ST_FINISH: begin
            if (load_rsp) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_byte_in   = rsp_byte_ff;
      rsp_bvalid_in = rsp_bvalid_ff;
      rsp_lend_in   = rsp_lend_ff;
      rsp_ovf_in    = rsp_ovf_ff;
      rsp_rxe_in    = rsp_rxe_ff;
      rsp_txe_in    = rsp_txe_ff;
      if (load_rsp) begin
         rsp_valid_in  = 1'b1;
         rsp_byte_in   = popped_ff ? pop_byte : '0;
         rsp_bvalid_in = popped_ff;
         rsp_lend_in   = popped_ff && (op_ff == OP_RX_TAKE) &&
                         (pop_byte == CH_LF || pop_byte == CH_CR);
         rsp_ovf_in    = ovf_ff;
         rsp_rxe_in    = rx_stat.empty;
         rsp_txe_in    = tx_stat.empty;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      data_ff       <= data_in;
      word_ff       <= word_in;
      cnt_ff        <= cnt_in;
      to_rx_ff      <= to_rx_in;
      ovf_ff        <= ovf_in;
      popped_ff     <= popped_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_bvalid_ff <= rsp_bvalid_in;
      rsp_lend_ff   <= rsp_lend_in;
      rsp_ovf_ff    <= rsp_ovf_in;
      rsp_rxe_ff    <= rsp_rxe_in;
      rsp_txe_ff    <= rsp_txe_in;
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.out_byte  = rsp_byte_ff;
   assign rsp.out_valid = rsp_bvalid_ff;
   assign rsp.line_end  = rsp_lend_ff;
   assign rsp.overflow  = rsp_ovf_ff;
   assign rsp.rx_empty  = rsp_rxe_ff;
   assign rsp.tx_empty  = rsp_txe_ff;

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      !(rx_cmd.push && rx_stat.full) && !(tx_cmd.push && tx_stat.full))
      else $error("push issued into a full ring");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      !(rx_cmd.pop && rx_stat.empty) && !(tx_cmd.pop && tx_stat.empty))
      else $error("pop issued from an empty ring");

   a_one_access: assert property (@(posedge clock) disable iff (reset)
      $countones({rx_cmd.push, rx_cmd.pop, tx_cmd.push, tx_cmd.pop}) <= 1)
      else $error("more than one ring access in a cycle");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != ST_IDLE)
      else $error("accepted item did not start work");

   a_line_end_popped: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.line_end |-> rsp.out_valid)
      else $error("line end flagged without a popped byte");

endmodule

[sv/uart_ring_buffer_engine.sv]
// Receive and transmit byte rings for a UART, driven by one operation per item.
// The request channel (req_ch) carries an operation code, a data byte and a
// 32-bit word; the response channel (rsp_ch) returns exactly one result item
// per request item: a popped byte with its valid and line-end flags, an
// overflow flag, and the empty status of both rings after the operation.
// A shared sequencer handles one item at a time and drops req_ch.ready while
// busy. Each byte written goes through the single write port of its ring, one
// per cycle: one byte for a line byte or plain put, CR then LF for a put of
// LF, eight characters for a hex put. For a pop, the registered memory read
// lands while the result is formed. A NUL put or an unused operation code
// writes nothing. The result sits in an output register; if the receiver
// stalls, the finished result waits there and the sequencer holds the
// following item in its final state until the register frees up. New items
// are accepted while a result still waits to be taken.
// Reset clears both rings to empty (pointers and fill counts); the ring
// storage itself is not cleared, and only written entries are ever read.
module uart_ring_buffer_engine import urb_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   urb_req_if.sink    req_ch,
   urb_rsp_if.source  rsp_ch
);

   ring_cmd_type  rx_cmd, tx_cmd;
   ring_stat_type rx_stat, tx_stat;

   // Sequencer: decodes the operation, steps through byte writes and pops,
   // and owns the result register.
   urb_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .req     (req_ch),
      .rsp     (rsp_ch),
      .rx_cmd  (rx_cmd),
      .tx_cmd  (tx_cmd),
      .rx_stat (rx_stat),
      .tx_stat (tx_stat)
   );

   // Receive ring: filled by line bytes, drained by take operations.
   urb_ring u_rx_ring (
      .clock (clock),
      .reset (reset),
      .cmd   (rx_cmd),
      .stat  (rx_stat)
   );

   // Transmit ring: filled by puts and hex puts, drained by transmitter ticks.
   urb_ring u_tx_ring (
      .clock (clock),
      .reset (reset),
      .cmd   (tx_cmd),
      .stat  (tx_stat)
   );

endmodule

[dv/tb_top.sv]
module tb_top;
   import urb_pkg::*;

   // One request item as the sender presents it.
   typedef struct packed {
      logic [OP_W-1:0]   operation;
      logic [BYTE_W-1:0] data_byte;
      logic [WORD_W-1:0] hex_word;
   } uart_cmd_type;

   // One result item as the block returns it.
   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              out_valid;
      logic              line_end;
      logic              overflow;
      logic              rx_empty;
      logic              tx_empty;
   } uart_status_type;

   localparam int RX_RING = 0;
   localparam int TX_RING = 1;

   logic clock = 1'b0;
   logic reset = 1'b1;

   urb_req_if req_ch ();
   urb_rsp_if rsp_ch ();

   uart_ring_buffer_engine dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Both channels start from known values. After time zero the driver and
   // the receiver below take over, and they only change things at the
   // falling edge so that the block samples stable values at the rising edge.
   initial begin
      req_ch.valid     = 1'b0;
      req_ch.operation = '0;
      req_ch.data_byte = '0;
      req_ch.hex_word  = '0;
      rsp_ch.ready     = 1'b0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
   end

   // Our own copy of the two rings. The predictor runs when a request item
   // is accepted, so this state always matches what the block holds once the
   // same items have gone through it.
   logic [BYTE_W-1:0] ring_mem [2][RING_DEPTH];
   int                ring_rd  [2] = '{0, 0};
   int                ring_wr  [2] = '{0, 0};
   int                ring_cnt [2] = '{0, 0};

   uart_cmd_type    cmd_backlog[$];     // items waiting for the driver
   uart_status_type pending_status[$];  // predicted results, oldest first

   int queued_n    = 0;  // items handed to the driver so far
   int accepted_n  = 0;  // items the block has taken
   int fault_count = 0;
   bit idle_on     = 1'b1;
   int send_gap    = 0;
   int stall_left  = 0;
   bit req_taken   = 1'b0;

   uart_cmd_type    cmd_next;
   uart_cmd_type    cmd_seen;
   uart_status_type want;
   uart_status_type seen;

   // A write into a full ring is refused and leaves the ring untouched.
   function automatic bit ring_store(int r, logic [BYTE_W-1:0] b);
      if (ring_cnt[r] >= RING_DEPTH)
         return 1'b0;
      ring_mem[r][ring_wr[r]] = b;
      ring_wr[r] = (ring_wr[r] + 1) % RING_DEPTH;
      ring_cnt[r]++;
      return 1'b1;
   endfunction

   function automatic bit ring_fetch(int r, output logic [BYTE_W-1:0] b);
      b = '0;
      if (ring_cnt[r] == 0)
         return 1'b0;
      b = ring_mem[r][ring_rd[r]];
      ring_rd[r] = (ring_rd[r] + 1) % RING_DEPTH;
      ring_cnt[r]--;
      return 1'b1;
   endfunction

   // Applies one item to the ring copies and returns the status it must produce.
   function automatic uart_status_type predict_status(uart_cmd_type c);
      uart_status_type   s;
      logic [BYTE_W-1:0] b;
      logic [3:0]        nib;
      s = '0;
      case (c.operation)
         OP_RX_IN: begin
            s.overflow = !ring_store(RX_RING, c.data_byte);
         end
         OP_RX_TAKE: begin
            if (ring_fetch(RX_RING, b)) begin
               s.out_byte  = b;
               s.out_valid = 1'b1;
               s.line_end  = (b == CH_LF) || (b == CH_CR);
            end
         end
         OP_TX_PUT: begin
            // A NUL ends a string and is never stored. A line feed goes out
            // as CR LF; with one slot left only the CR fits.
            if (c.data_byte != '0) begin
               if (c.data_byte == CH_LF && !ring_store(TX_RING, CH_CR))
                  s.overflow = 1'b1;
               if (!ring_store(TX_RING, c.data_byte))
                  s.overflow = 1'b1;
            end
         end
         OP_TX_HEX: begin
            // Eight lowercase digits, most significant nibble first. Digits
            // that no longer fit are dropped one by one.
            for (int k = 7; k >= 0; k--) begin
               nib = c.hex_word[4*k +: 4];
               b = {4'h0, nib} + ((nib >= NIBBLE_TEN) ? HEX_ALPHA_OFS : HEX_DIGIT_OFS);
               if (!ring_store(TX_RING, b))
                  s.overflow = 1'b1;
            end
         end
         OP_TX_READY: begin
            if (ring_fetch(TX_RING, b)) begin
               s.out_byte  = b;
               s.out_valid = 1'b1;
            end
         end
         default: begin
            // Unused codes change nothing; only the empty flags are reported.
         end
      endcase
      s.rx_empty = (ring_cnt[RX_RING] == 0);
      s.tx_empty = (ring_cnt[TX_RING] == 0);
      return s;
   endfunction

   // Driver. A presented item stays on the channel until the block takes it.
   // Between items the sender may go quiet while idling is on.
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_taken) begin
         if (send_gap > 0) begin
            req_ch.valid <= 1'b0;
            send_gap <= send_gap - 1;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            req_ch.valid <= 1'b0;
            send_gap <= $urandom_range(0, 3);
         end else if (cmd_backlog.size() > 0) begin
            cmd_next = cmd_backlog.pop_front();
            req_ch.valid     <= 1'b1;
            req_ch.operation <= cmd_next.operation;
            req_ch.data_byte <= cmd_next.data_byte;
            req_ch.hex_word  <= cmd_next.hex_word;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Receiver. It stalls in random bursts while idling is on,
   // so that results back up into the block's output register at every phase
   // of its work.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left <= $urandom_range(0, 3);
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // Monitor. Accepted requests feed the predictor; accepted results are
   // checked against the oldest prediction.
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_ch.valid && req_ch.ready;
         if (req_ch.valid && req_ch.ready) begin
            cmd_seen.operation = req_ch.operation;
            cmd_seen.data_byte = req_ch.data_byte;
            cmd_seen.hex_word  = req_ch.hex_word;
            pending_status.push_back(predict_status(cmd_seen));
            accepted_n <= accepted_n + 1;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            seen.out_byte  = rsp_ch.out_byte;
            seen.out_valid = rsp_ch.out_valid;
            seen.line_end  = rsp_ch.line_end;
            seen.overflow  = rsp_ch.overflow;
            seen.rx_empty  = rsp_ch.rx_empty;
            seen.tx_empty  = rsp_ch.tx_empty;
            if (pending_status.size() == 0) begin
               fault_count++;
               if (fault_count <= 10)
                  $display("unexpected result: byte %02h vld %b eol %b ovf %b rxe %b txe %b",
                           seen.out_byte, seen.out_valid, seen.line_end, seen.overflow,
                           seen.rx_empty, seen.tx_empty);
            end else begin
               want = pending_status.pop_front();
               if (seen !== want) begin
                  fault_count++;
                  if (fault_count <= 10)
                     $display({"result mismatch: expected byte %02h vld %b eol %b ovf %b",
                               " rxe %b txe %b, got byte %02h vld %b eol %b ovf %b",
                               " rxe %b txe %b"},
                              want.out_byte, want.out_valid, want.line_end, want.overflow,
                              want.rx_empty, want.tx_empty,
                              seen.out_byte, seen.out_valid, seen.line_end, seen.overflow,
                              seen.rx_empty, seen.tx_empty);
               end
            end
         end
      end
   end

   task automatic queue_cmd(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] data,
                            input logic [WORD_W-1:0] word);
      uart_cmd_type c;
      c.operation = op;
      c.data_byte = data;
      c.hex_word  = word;
      cmd_backlog.push_back(c);
      queued_n++;
   endtask

   // Line ends and NUL come up often, since they take their own paths.
   function automatic logic [BYTE_W-1:0] pick_byte();
      case ($urandom_range(0, 15))
         0, 1:    return CH_LF;
         2, 3:    return CH_CR;
         4:       return '0;
         default: return BYTE_W'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [WORD_W-1:0] pick_word();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         default: return $urandom;
      endcase
   endfunction

   // Random operations. The draining mix favors pops so that full rings
   // empty out again while pushes keep landing on them.
   task automatic queue_random(input int count, input bit draining);
      int                pick;
      logic [OP_W-1:0]   op;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 3)
            op = OP_W'($urandom_range(OP_TX_READY + 1, (1 << OP_W) - 1));
         else if (pick < (draining ? 13 : 28))
            op = OP_RX_IN;
         else if (pick < (draining ? 50 : 48))
            op = OP_RX_TAKE;
         else if (pick < (draining ? 62 : 73))
            op = OP_TX_PUT;
         else if (pick < (draining ? 65 : 83))
            op = OP_TX_HEX;
         else
            op = OP_TX_READY;
         queue_cmd(op, pick_byte(), pick_word());
      end
   endtask

   // Holds the sender back until every item has been taken and every result
   // has come home, so that our ring copies describe the block exactly.
   task automatic wait_for_quiet();
      while (accepted_n != queued_n || pending_status.size() != 0)
         @(negedge clock);
      @(posedge clock);
   endtask

   initial begin
      int free_slots;

      // Directed opening: pops from empty rings, byte extremes, both line
      // ends, a put of LF that expands to CR LF, a NUL put, every hex digit
      // and the unused operation codes.
      queue_cmd(OP_TX_READY, 8'hFF, '1);
      queue_cmd(OP_RX_TAKE, 8'hFF, '1);
      queue_cmd(OP_RX_IN, 8'h00, '0);
      queue_cmd(OP_RX_IN, 8'hFF, '0);
      queue_cmd(OP_RX_IN, CH_LF, '0);
      queue_cmd(OP_RX_IN, CH_CR, '0);
      repeat (5) queue_cmd(OP_RX_TAKE, '0, '0);
      queue_cmd(OP_TX_PUT, 8'h41, '0);
      queue_cmd(OP_TX_PUT, CH_LF, '0);
      queue_cmd(OP_TX_PUT, 8'h00, '1);
      queue_cmd(OP_TX_PUT, 8'hFF, '0);
      queue_cmd(OP_TX_PUT, CH_CR, '0);
      queue_cmd(OP_TX_HEX, '0, 32'h0123_4567);
      queue_cmd(OP_TX_HEX, '0, 32'h89ab_cdef);
      queue_cmd(OP_W'(OP_TX_READY + 1), 8'hA5, 32'hdead_beef);
      queue_cmd(OP_W'(OP_TX_READY + 2), 8'h5A, '1);
      queue_cmd(OP_W'(OP_TX_READY + 3), 8'hFF, '0);
      repeat (4) queue_cmd(OP_TX_READY, '0, '0);

      queue_random(100, 1'b0);

      // Fill the transmit ring to one free slot with hex and plain puts, then
      // put LF so that only its CR fits. Once full, every kind of put must
      // overflow. Freeing five slots then lets a hex put land partway.
      wait_for_quiet();
      idle_on = 1'b0;
      free_slots = RING_DEPTH - ring_cnt[TX_RING];
      if (free_slots > 0) begin
         repeat ((free_slots - 1) / 8) queue_cmd(OP_TX_HEX, pick_byte(), $urandom);
         repeat ((free_slots - 1) % 8)
            queue_cmd(OP_TX_PUT, BYTE_W'($urandom_range(CH_CR + 1, 255)), '0);
         queue_cmd(OP_TX_PUT, CH_LF, '0);
      end
      queue_cmd(OP_TX_PUT, BYTE_W'($urandom_range(CH_CR + 1, 255)), $urandom);
      queue_cmd(OP_TX_PUT, CH_LF, $urandom);
      queue_cmd(OP_TX_HEX, pick_byte(), $urandom);
      repeat (5) queue_cmd(OP_TX_READY, pick_byte(), $urandom);
      queue_cmd(OP_TX_HEX, pick_byte(), $urandom);

      // Fill the receive ring past its depth so the last bytes are dropped.
      // The write pointer wraps on the way.
      wait_for_quiet();
      idle_on = 1'b1;
      repeat (RING_DEPTH - ring_cnt[RX_RING] + 3) queue_cmd(OP_RX_IN, pick_byte(), $urandom);

      queue_random(200, 1'b1);

      // The last stretch runs with no gaps and no stalls at all.
      wait_for_quiet();
      idle_on = 1'b0;
      queue_random(70, 1'b0);

      wait_for_quiet();
      repeat (20) @(negedge clock);
      if (fault_count == 0)
         $display("[uart_ring_buffer_engine] OK");
      else
         $display("[uart_ring_buffer_engine] ERROR");
      $finish;
   end

   // A hung handshake ends the run here.
   initial begin
      #10_000_000;
      $display("[uart_ring_buffer_engine] ERROR");
      $finish;
   end

endmodule
